// ===== src/pit_pkg.sv =====
// Shared constants for the point-in-triangle test: register indexes and port widths.
package pit_pkg;

    // Width of the configuration register index.
    localparam int CFG_INDEX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_VERTEX_A = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_VERTEX_B = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_VERTEX_C = 2'd2;

    // Result item: inside flag in bit 0, degenerate flag in bit 1, zero padded to a byte.
    localparam int OUT_TDATA_W = 8;
    localparam int OUT_INSIDE  = 0;
    localparam int OUT_DEGEN   = 1;

    // The model keeps at most 64 bits of each vertex register.
    localparam int VTX_KEEP_MAX = 64;

endpackage

// ===== src/pit_edge.sv =====
// Edge stage: forms the edge vectors B-A, C-A and P-A.
module pit_edge #(
    parameter int COORD_BITS = 16
) (
    input  logic                                clk,
    input  logic                                ld,
    input  logic [3*COORD_BITS-1:0]             vtx_a,
    input  logic [3*COORD_BITS-1:0]             vtx_b,
    input  logic [3*COORD_BITS-1:0]             vtx_c,
    input  logic [3*COORD_BITS-1:0]             point,
    output logic [2:0][COORD_BITS:0]            e0,
    output logic [2:0][COORD_BITS:0]            e1,
    output logic [2:0][COORD_BITS:0]            e2
);
    import pit_pkg::*;

    localparam int C = COORD_BITS;
    localparam int E = COORD_BITS + 1;

    logic [2:0][E-1:0] e0_next, e1_next, e2_next;
    logic [2:0][E-1:0] e0_reg, e1_reg, e2_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            e0_next[k] = E'($signed(vtx_b[k*C +: C])) - E'($signed(vtx_a[k*C +: C]));
            e1_next[k] = E'($signed(vtx_c[k*C +: C])) - E'($signed(vtx_a[k*C +: C]));
            e2_next[k] = E'($signed(point[k*C +: C])) - E'($signed(vtx_a[k*C +: C]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            e0_reg <= e0_next;
            e1_reg <= e1_next;
            e2_reg <= e2_next;
        end
    end

    assign e0 = e0_reg;
    assign e1 = e1_reg;
    assign e2 = e2_reg;

endmodule

// ===== src/pit_dot.sv =====
// Dot product stages: per-axis products, then the three-term sums d00, d01, d02, d11, d12.
module pit_dot #(
    parameter int COORD_BITS = 16
) (
    input  logic                                clk,
    input  logic [1:0]                          ld,
    input  logic [2:0][COORD_BITS:0]            e0,
    input  logic [2:0][COORD_BITS:0]            e1,
    input  logic [2:0][COORD_BITS:0]            e2,
    output logic signed [2*COORD_BITS+3:0]      d00,
    output logic signed [2*COORD_BITS+3:0]      d01,
    output logic signed [2*COORD_BITS+3:0]      d02,
    output logic signed [2*COORD_BITS+3:0]      d11,
    output logic signed [2*COORD_BITS+3:0]      d12
);
    import pit_pkg::*;

    localparam int E = COORD_BITS + 1;
    localparam int P = 2 * E;
    localparam int D = 2 * E + 2;

    logic [2:0][P-1:0] p00_reg, p01_reg, p02_reg, p11_reg, p12_reg;
    logic [2:0][P-1:0] p00_next, p01_next, p02_next, p11_next, p12_next;
    logic signed [D-1:0] d00_next, d01_next, d02_next, d11_next, d12_next;
    logic signed [D-1:0] d00_reg, d01_reg, d02_reg, d11_reg, d12_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            p00_next[k] = P'($signed(e0[k]) * $signed(e0[k]));
            p01_next[k] = P'($signed(e0[k]) * $signed(e1[k]));
            p02_next[k] = P'($signed(e0[k]) * $signed(e2[k]));
            p11_next[k] = P'($signed(e1[k]) * $signed(e1[k]));
            p12_next[k] = P'($signed(e1[k]) * $signed(e2[k]));
        end
    end

    always_comb
    begin
        d00_next = D'($signed(p00_reg[0])) + D'($signed(p00_reg[1])) + D'($signed(p00_reg[2]));
        d01_next = D'($signed(p01_reg[0])) + D'($signed(p01_reg[1])) + D'($signed(p01_reg[2]));
        d02_next = D'($signed(p02_reg[0])) + D'($signed(p02_reg[1])) + D'($signed(p02_reg[2]));
        d11_next = D'($signed(p11_reg[0])) + D'($signed(p11_reg[1])) + D'($signed(p11_reg[2]));
        d12_next = D'($signed(p12_reg[0])) + D'($signed(p12_reg[1])) + D'($signed(p12_reg[2]));
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            p00_reg <= p00_next;
            p01_reg <= p01_next;
            p02_reg <= p02_next;
            p11_reg <= p11_next;
            p12_reg <= p12_next;
        end
        if (ld[1])
        begin
            d00_reg <= d00_next;
            d01_reg <= d01_next;
            d02_reg <= d02_next;
            d11_reg <= d11_next;
            d12_reg <= d12_next;
        end
    end

    assign d00 = d00_reg;
    assign d01 = d01_reg;
    assign d02 = d02_reg;
    assign d11 = d11_reg;
    assign d12 = d12_reg;

endmodule

// ===== src/pit_wmul.sv =====
// Two-stage signed multiplier built from four half-width partial products.
module pit_wmul #(
    parameter int DW = 36
) (
    input  logic                    clk,
    input  logic [1:0]              ld,
    input  logic signed [DW-1:0]    a,
    input  logic signed [DW-1:0]    b,
    output logic signed [2*DW-1:0]  p
);
    import pit_pkg::*;

    localparam int LO = (DW + 1) / 2;
    localparam int HI = DW - LO;
    localparam int PW = 2 * DW;

    logic [LO-1:0]          al, bl;
    logic signed [HI-1:0]   ah, bh;
    logic signed [LO:0]     al_s, bl_s;

    logic [2*LO-1:0]        pll_next, pll_reg;
    logic signed [DW:0]     plh_next, plh_reg;
    logic signed [DW:0]     phl_next, phl_reg;
    logic signed [2*HI-1:0] phh_next, phh_reg;
    logic signed [PW-1:0]   p_next, p_reg;
    logic signed [PW-1:0]   mid;

    always_comb
    begin
        al       = a[LO-1:0];
        bl       = b[LO-1:0];
        ah       = a[DW-1:LO];
        bh       = b[DW-1:LO];
        al_s     = {1'b0, al};
        bl_s     = {1'b0, bl};
        pll_next = al * bl;
        plh_next = al_s * bh;
        phl_next = ah * bl_s;
        phh_next = ah * bh;
    end

    // Reassemble: high*high weighs 2^(2*LO), the cross terms 2^LO.
    always_comb
    begin
        mid    = PW'(plh_reg) + PW'(phl_reg);
        p_next = (PW'(phh_reg) <<< (2 * LO)) + (mid <<< LO) + $signed(PW'(pll_reg));
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            pll_reg <= pll_next;
            plh_reg <= plh_next;
            phl_reg <= phl_next;
            phh_reg <= phh_next;
        end
        if (ld[1])
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

// ===== src/pit_decide.sv =====
// Decision stages: forms denom, un and vn, then the inside and degenerate flags.
module pit_decide #(
    parameter int PW = 72
) (
    input  logic                    clk,
    input  logic [1:0]              ld,
    input  logic signed [PW-1:0]    d00_d11,
    input  logic signed [PW-1:0]    d01_d01,
    input  logic signed [PW-1:0]    d11_d02,
    input  logic signed [PW-1:0]    d01_d12,
    input  logic signed [PW-1:0]    d00_d12,
    input  logic signed [PW-1:0]    d01_d02,
    output logic                    inside_res,
    output logic                    degenerate
);
    import pit_pkg::*;

    localparam int W = PW + 2;

    logic signed [W-1:0] denom_next, un_next, vn_next;
    logic signed [W-1:0] denom_reg, un_reg, vn_reg;
    logic signed [W-1:0] uv_sum;
    logic                ins_next, deg_next;
    logic                ins_reg, deg_reg;

    always_comb
    begin
        denom_next = W'(d00_d11) - W'(d01_d01);
        un_next    = W'(d11_d02) - W'(d01_d12);
        vn_next    = W'(d00_d12) - W'(d01_d02);
    end

    // A triangle with no positive area is reported as degenerate and never contains the point.
    always_comb
    begin
        uv_sum   = un_reg + vn_reg;
        deg_next = denom_reg[W-1] || (denom_reg == '0);
        ins_next = !deg_next
                   && !un_reg[W-1] && (un_reg <= denom_reg)
                   && !vn_reg[W-1] && (vn_reg <= denom_reg)
                   && (uv_sum <= denom_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            denom_reg <= denom_next;
            un_reg    <= un_next;
            vn_reg    <= vn_next;
        end
        if (ld[1])
        begin
            ins_reg <= ins_next;
            deg_reg <= deg_next;
        end
    end

    assign inside_res = ins_reg;
    assign degenerate = deg_reg;

endmodule

// ===== src/point_in_triangle_test.sv =====
// Top level of the point-in-triangle test: configuration registers, pipeline control, datapath.
//
// This block tests 3D points against one triangle whose vertices A, B and C sit in three
// configuration registers (index 0, 1, 2; each packed z:y:x with x in the low bits). For every
// input item it returns one result item: inside_res is 1 when the point, projected onto the
// triangle's plane, lies within the triangle or on its edges, and degenerate is 1 when the
// triangle has zero area, in which case inside_res is 0. The test uses exact integer barycentric
// arithmetic, so no rounding ever moves a point across an edge. The datapath is a seven-stage
// pipeline: edge vectors, per-axis products, dot product sums, partial products of the wide
// multiplies, their reassembly, the denom/un/vn differences, and the final compares. One item is
// accepted every clock cycle while the output side does not stall. Every stage has its own valid
// bit and loads whenever the stage after it is empty or moving, so back-pressure from the output
// only stops the stages that are full, and bubbles close up. Vertex registers should be written
// only while no item is in flight; writes to an index beyond the three registers are ignored, and
// cfg_ready is always high. With COORD_BITS above 21 the register bits above bit 63 read as zero.
module point_in_triangle_test #(
    parameter int COORD_BITS = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // Configuration write channel.
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [pit_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  logic [3*COORD_BITS-1:0]                 cfg_data,
    // Input items; tdata from the lowest bit up: point_x, point_y, point_z, zero padding.
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  logic [((3*COORD_BITS+7)/8)*8-1:0]       s_axis_tdata,
    // Result items; tdata from the lowest bit up: inside_res, degenerate, zero padding.
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    output logic [pit_pkg::OUT_TDATA_W-1:0]         m_axis_tdata
);
    import pit_pkg::*;

    localparam int C      = COORD_BITS;
    localparam int VB     = 3 * C;
    localparam int E      = C + 1;
    localparam int D      = 2 * E + 2;
    localparam int PW     = 2 * D;
    localparam int NSTAGE = 7;
    localparam int KEEP   = (VB > VTX_KEEP_MAX) ? VTX_KEEP_MAX : VB;
    localparam logic [VB-1:0] VTX_MASK = {VB{1'b1}} >> (VB - KEEP);

    // Vertex registers.
    logic [VB-1:0] vtx_a_reg, vtx_b_reg, vtx_c_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vtx_a_reg <= '0;
            vtx_b_reg <= '0;
            vtx_c_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_VERTEX_A: vtx_a_reg <= cfg_data & VTX_MASK;
                REG_VERTEX_B: vtx_b_reg <= cfg_data & VTX_MASK;
                REG_VERTEX_C: vtx_c_reg <= cfg_data & VTX_MASK;
                default:      ;
            endcase
        end
    end

    // Pipeline control: a stage loads when it is empty or the stage after it is loading.
    logic [NSTAGE:1] vld_reg;
    logic [NSTAGE:1] rdy;

    always_comb
    begin
        rdy[NSTAGE] = !vld_reg[NSTAGE] || m_axis_tready;
        for (int i = NSTAGE - 1; i >= 1; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[1])
            begin
                vld_reg[1] <= s_axis_tvalid;
            end
            for (int i = 2; i <= NSTAGE; i++)
            begin
                if (rdy[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    assign s_axis_tready = rdy[1];
    assign m_axis_tvalid = vld_reg[NSTAGE];

    // Datapath.
    logic [2:0][E-1:0]      e0, e1, e2;
    logic signed [D-1:0]    d00, d01, d02, d11, d12;
    logic signed [PW-1:0]   d00_d11, d01_d01, d11_d02, d01_d12, d00_d12, d01_d02;
    logic                   inside_res, degenerate;

    pit_edge #(.COORD_BITS(COORD_BITS)) u_edge (
        .clk   (clk),
        .ld    (rdy[1]),
        .vtx_a (vtx_a_reg),
        .vtx_b (vtx_b_reg),
        .vtx_c (vtx_c_reg),
        .point (s_axis_tdata[VB-1:0]),
        .e0    (e0),
        .e1    (e1),
        .e2    (e2)
    );

    pit_dot #(.COORD_BITS(COORD_BITS)) u_dot (
        .clk (clk),
        .ld  (rdy[3:2]),
        .e0  (e0),
        .e1  (e1),
        .e2  (e2),
        .d00 (d00),
        .d01 (d01),
        .d02 (d02),
        .d11 (d11),
        .d12 (d12)
    );

    pit_wmul #(.DW(D)) u_mul_d00_d11 (.clk(clk), .ld(rdy[5:4]), .a(d00), .b(d11), .p(d00_d11));
    pit_wmul #(.DW(D)) u_mul_d01_d01 (.clk(clk), .ld(rdy[5:4]), .a(d01), .b(d01), .p(d01_d01));
    pit_wmul #(.DW(D)) u_mul_d11_d02 (.clk(clk), .ld(rdy[5:4]), .a(d11), .b(d02), .p(d11_d02));
    pit_wmul #(.DW(D)) u_mul_d01_d12 (.clk(clk), .ld(rdy[5:4]), .a(d01), .b(d12), .p(d01_d12));
    pit_wmul #(.DW(D)) u_mul_d00_d12 (.clk(clk), .ld(rdy[5:4]), .a(d00), .b(d12), .p(d00_d12));
    pit_wmul #(.DW(D)) u_mul_d01_d02 (.clk(clk), .ld(rdy[5:4]), .a(d01), .b(d02), .p(d01_d02));

    pit_decide #(.PW(PW)) u_decide (
        .clk        (clk),
        .ld         (rdy[7:6]),
        .d00_d11    (d00_d11),
        .d01_d01    (d01_d01),
        .d11_d02    (d11_d02),
        .d01_d12    (d01_d12),
        .d00_d12    (d00_d12),
        .d01_d02    (d01_d02),
        .inside_res (inside_res),
        .degenerate (degenerate)
    );

    always_comb
    begin
        m_axis_tdata             = '0;
        m_axis_tdata[OUT_INSIDE] = inside_res;
        m_axis_tdata[OUT_DEGEN]  = degenerate;
    end

endmodule

// ===== src/pit_checker.sv =====
// Port-level checks for the point-in-triangle test and the bind that attaches them.
module pit_checker (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_axis_tready,
    input  logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    input  logic [pit_pkg::OUT_TDATA_W-1:0]         m_axis_tdata
);
    import pit_pkg::*;

    // A stalled result item holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result item changed while stalled");

    // A degenerate triangle never reports the point as inside.
    a_degen_outside: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[OUT_DEGEN] |-> !m_axis_tdata[OUT_INSIDE])
        else $error("inside reported for a degenerate triangle");

    // With the output side ready, the whole pipeline moves and the input side never stalls.
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output is ready");

    // Padding bits of a result item stay zero.
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:OUT_DEGEN+1] == '0))
        else $error("nonzero padding in result item");

endmodule

bind point_in_triangle_test pit_checker u_pit_checker (.*);
